/* rtl/srecord_line_decoder_core_defines.svh */
// Assertion macros shared by the S-record line decoder RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef SRECORD_LINE_DECODER_CORE_DEFINES_SVH
`define SRECORD_LINE_DECODER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRLD_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SRLD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/srld_pkg.sv */
// Shared types and constants of the S-record line decoder.
// No dependencies; the RTL modules refer to it by scoped names.
package srld_pkg;

    // Classified character, passed from the front end through the queue.
    typedef struct packed {
        logic       is_s;
        logic       is_digit;
        logic       is_hex;
        logic [3:0] value;
        logic       last;
    } srld_item_t;

    // Queue fill flags seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } srld_q_stat_t;

    typedef enum logic [2:0] {
        PH_S,
        PH_TYPE,
        PH_COUNT,
        PH_ADDR,
        PH_DATA,
        PH_SUM,
        PH_DONE
    } srld_phase_t;

    localparam logic [7:0] CHAR_S     = 8'h53;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UF    = 8'h46;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LF    = 8'h66;

    localparam logic [3:0] KIND_NONE  = 4'd15;

    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_START    = 4'd1;
    localparam logic [3:0] ST_END      = 4'd2;
    localparam logic [3:0] ST_COUNT    = 4'd3;
    localparam logic [3:0] ST_NO_S     = 4'd4;
    localparam logic [3:0] ST_BAD_TYPE = 4'd5;
    localparam logic [3:0] ST_WIDTH    = 4'd6;
    localparam logic [3:0] ST_HEX      = 4'd7;
    localparam logic [3:0] ST_SHORT    = 4'd8;
    localparam logic [3:0] ST_CHECKSUM = 4'd9;

    localparam logic [2:0] AW_RESET    = 3'd2;

endpackage

/* rtl/srld_front.sv */
// Front end of the S-record decoder: takes characters and classifies them.
// Depends on srld_pkg; feeds srld_queue.
module srld_front (
    input  logic [7:0]           s_tdata,   // [7:0] char_code
    input  logic                 s_tvalid,
    input  logic                 s_tlast,
    output logic                 s_tready,
    input  srld_pkg::srld_q_stat_t q_stat,
    output logic                 push,
    output srld_pkg::srld_item_t push_item
);

    function automatic srld_pkg::srld_item_t classify(input logic [7:0] c, input logic last);
        srld_pkg::srld_item_t it;
        logic [7:0]           off;
        it.is_s     = (c == srld_pkg::CHAR_S);
        it.is_digit = (c >= srld_pkg::CHAR_0) && (c <= srld_pkg::CHAR_9);
        it.is_hex   = 1'b1;
        it.last     = last;
        if (it.is_digit) begin
            off = c - srld_pkg::CHAR_0;
        end else if ((c >= srld_pkg::CHAR_UA) && (c <= srld_pkg::CHAR_UF)) begin
            off = c - srld_pkg::CHAR_UA + 8'd10;
        end else if ((c >= srld_pkg::CHAR_LA) && (c <= srld_pkg::CHAR_LF)) begin
            off = c - srld_pkg::CHAR_LA + 8'd10;
        end else begin
            off       = 8'd0;
            it.is_hex = 1'b0;
        end
        it.value = off[3:0];
        return it;
    endfunction

    assign s_tready  = !q_stat.full;
    assign push      = s_tvalid && s_tready;
    assign push_item = classify(s_tdata, s_tlast);

endmodule

/* rtl/srld_queue.sv */
// Short queue of classified characters between front end and parser.
// Depends on srld_pkg.
module srld_queue #(
    parameter int DEPTH = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  srld_pkg::srld_item_t  push_item,
    input  logic                  pop,
    output srld_pkg::srld_item_t  head_item,
    output srld_pkg::srld_q_stat_t q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    srld_pkg::srld_item_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item    = mem[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);

endmodule

/* rtl/srld_back.sv */
// Parser of the S-record decoder: record state machine and result register.
// Depends on srld_pkg and the assertion macros in the defines header.
`include "srecord_line_decoder_core_defines.svh"

module srld_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [2:0]             address_width,
    input  srld_pkg::srld_item_t   head_item,
    input  srld_pkg::srld_q_stat_t q_stat,
    output logic                   pop,
    output logic [63:0]            m_tdata,
    output logic [0:0]             m_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready
);

    srld_pkg::srld_phase_t phase_reg, phase_next;
    logic [3:0]  nibble_reg, nibble_next;
    logic        half_reg, half_next;
    logic [3:0]  rtype_reg, rtype_next;
    logic [7:0]  remain_reg, remain_next;
    logic [7:0]  sum_reg, sum_next;
    logic [31:0] addr_reg, addr_next;
    logic [7:0]  index_reg, index_next;
    logic [3:0]  err_reg, err_next;
    logic [7:0]  dcount_reg, dcount_next;

    logic        out_valid_reg;
    logic        out_status_reg;
    logic [63:0] out_data_reg;

    logic        out_free;
    logic        emit_data;
    logic        out_load;
    logic [7:0]  byte_val;
    logic [2:0]  abytes;
    logic [3:0]  code;
    logic [63:0] out_data_next;

    assign out_free = !out_valid_reg || m_tready;
    assign pop      = !q_stat.empty && out_free;
    assign byte_val = {nibble_reg, head_item.value};
    assign abytes   = {1'b0, rtype_reg[1:0]} + 3'd1;

    always_comb begin
        phase_next  = phase_reg;
        nibble_next = nibble_reg;
        half_next   = half_reg;
        rtype_next  = rtype_reg;
        remain_next = remain_reg;
        sum_next    = sum_reg;
        addr_next   = addr_reg;
        index_next  = index_reg;
        err_next    = err_reg;
        dcount_next = dcount_reg;
        emit_data   = 1'b0;
        code        = srld_pkg::ST_OK;

        if (pop) begin
            unique case (phase_reg)
                srld_pkg::PH_S: begin
                    if (head_item.is_s) begin
                        phase_next = srld_pkg::PH_TYPE;
                    end else begin
                        err_next   = srld_pkg::ST_NO_S;
                        phase_next = srld_pkg::PH_DONE;
                    end
                end
                srld_pkg::PH_TYPE: begin
                    phase_next = srld_pkg::PH_DONE;
                    if (!head_item.is_digit) begin
                        err_next = srld_pkg::ST_BAD_TYPE;
                    end else begin
                        rtype_next = head_item.value;
                        priority if (head_item.value == 4'd0) begin
                            err_next = srld_pkg::ST_START;
                        end else if ((head_item.value == 4'd5) || (head_item.value == 4'd6)) begin
                            err_next = srld_pkg::ST_COUNT;
                        end else if (head_item.value >= 4'd7) begin
                            err_next = srld_pkg::ST_END;
                        end else if (head_item.value == 4'd4) begin
                            err_next = srld_pkg::ST_BAD_TYPE;
                        end else if (({2'b0, head_item.value[1:0]} + 4'd1)
                                     > {1'b0, address_width}) begin
                            err_next = srld_pkg::ST_WIDTH;
                        end else begin
                            phase_next = srld_pkg::PH_COUNT;
                        end
                    end
                end
                srld_pkg::PH_COUNT, srld_pkg::PH_ADDR,
                srld_pkg::PH_DATA, srld_pkg::PH_SUM: begin
                    if (!head_item.is_hex) begin
                        err_next   = srld_pkg::ST_HEX;
                        phase_next = srld_pkg::PH_DONE;
                    end else if (!half_reg) begin
                        nibble_next = head_item.value;
                        half_next   = 1'b1;
                    end else begin
                        half_next = 1'b0;
                        sum_next  = sum_reg + byte_val;
                        unique case (phase_reg)
                            srld_pkg::PH_COUNT: begin
                                if (byte_val < ({5'b0, abytes} + 8'd1)) begin
                                    err_next   = srld_pkg::ST_SHORT;
                                    phase_next = srld_pkg::PH_DONE;
                                end else begin
                                    dcount_next = byte_val - {5'b0, abytes} - 8'd1;
                                    remain_next = {5'b0, abytes};
                                    phase_next  = srld_pkg::PH_ADDR;
                                end
                            end
                            srld_pkg::PH_ADDR: begin
                                addr_next   = {addr_reg[23:0], byte_val};
                                remain_next = remain_reg - 8'd1;
                                if (remain_reg == 8'd1) begin
                                    remain_next = dcount_reg;
                                    index_next  = 8'd0;
                                    phase_next  = (dcount_reg == 8'd0) ? srld_pkg::PH_SUM
                                                                       : srld_pkg::PH_DATA;
                                end
                            end
                            srld_pkg::PH_DATA: begin
                                emit_data   = 1'b1;
                                index_next  = index_reg + 8'd1;
                                remain_next = remain_reg - 8'd1;
                                if (remain_reg == 8'd1) begin
                                    phase_next = srld_pkg::PH_SUM;
                                end
                            end
                            default: begin
                                // Checksum byte: ones' complement of the running sum.
                                err_next   = ((~byte_val) == sum_reg) ? srld_pkg::ST_OK
                                                                      : srld_pkg::ST_CHECKSUM;
                                phase_next = srld_pkg::PH_DONE;
                            end
                        endcase
                    end
                end
                srld_pkg::PH_DONE: begin
                end
                default: begin
                end
            endcase
        end

        priority if (phase_next == srld_pkg::PH_DONE) begin
            code = err_next;
        end else if (phase_next == srld_pkg::PH_S) begin
            code = srld_pkg::ST_NO_S;
        end else if (phase_next == srld_pkg::PH_TYPE) begin
            code = srld_pkg::ST_BAD_TYPE;
        end else begin
            code = srld_pkg::ST_HEX;
        end

        out_load = pop && (emit_data || head_item.last);
        if (head_item.last) begin
            out_data_next = {dcount_next, code, rtype_next, 8'd0, 8'd0, addr_next};
        end else begin
            out_data_next = {dcount_reg, srld_pkg::ST_OK, rtype_reg, byte_val,
                             index_reg, addr_reg};
        end

        // The line end restarts the parser for the next line.
        if (pop && head_item.last) begin
            phase_next  = srld_pkg::PH_S;
            nibble_next = 4'd0;
            half_next   = 1'b0;
            rtype_next  = srld_pkg::KIND_NONE;
            remain_next = 8'd0;
            sum_next    = 8'd0;
            addr_next   = 32'd0;
            index_next  = 8'd0;
            err_next    = srld_pkg::ST_OK;
            dcount_next = 8'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= srld_pkg::PH_S;
            nibble_reg    <= 4'd0;
            half_reg      <= 1'b0;
            rtype_reg     <= srld_pkg::KIND_NONE;
            remain_reg    <= 8'd0;
            sum_reg       <= 8'd0;
            addr_reg      <= 32'd0;
            index_reg     <= 8'd0;
            err_reg       <= srld_pkg::ST_OK;
            dcount_reg    <= 8'd0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            nibble_reg  <= nibble_next;
            half_reg    <= half_next;
            rtype_reg   <= rtype_next;
            remain_reg  <= remain_next;
            sum_reg     <= sum_next;
            addr_reg    <= addr_next;
            index_reg   <= index_next;
            err_reg     <= err_next;
            dcount_reg  <= dcount_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg   <= out_data_next;
            out_status_reg <= head_item.last;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_status_reg;

    `SRLD_ASSERT_NEXT(a_line_end_gives_status, aclk, aresetn, pop && head_item.last, out_valid_reg && out_status_reg, "line end did not produce a status result")
    `SRLD_ASSERT_SAME(a_status_zero_fields, aclk, aresetn, out_valid_reg && out_status_reg, out_data_reg[47:32] == 16'd0, "status result carries data byte or index")
    `SRLD_ASSERT_SAME(a_index_in_range, aclk, aresetn, out_valid_reg && !out_status_reg, out_data_reg[39:32] < out_data_reg[63:56], "data byte index beyond declared count")
    `SRLD_ASSERT_SAME(a_idle_line_clear, aclk, aresetn, phase_reg == srld_pkg::PH_S, (sum_reg == 8'd0) && !half_reg && (addr_reg == 32'd0), "parser not cleared at line start")

endmodule

/* rtl/srecord_line_decoder_core.sv */
// Top level of the S-record line decoder: front end, queue and parser.
// Depends on srld_pkg, srld_front, srld_queue and srld_back.

// Decodes Motorola S-record text one character per request on the s_ channel,
// with s_tlast marking the last character of a line. Each data byte of an S1,
// S2 or S3 record comes out on the m_ channel as soon as its second hex digit
// arrives, and the line-end character always yields exactly one status result
// (m_tuser = 1) that reports the record kind or the first error seen. A
// consumer should drop the bytes of a line whose status is not "data ok".
// The block takes one character every clock cycle unless a held result stalls the parser:
// the parser retires one queued character per cycle, so throughput is set only by the output side.
// A result is offered on m_ from the result register: an accepted character is
// first written into the queue, then parsed from the head of the queue into the
// result register. The queue of FIFO_DEPTH classified characters lets input and
// output stall independently. The address_width register (reset value 2) is
// written through the cfg_ channel; the user must write it only while no line is
// in flight, as the block itself does not enforce it. It accepts a write every cycle.
module srecord_line_decoder_core #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input characters.
    input  logic [7:0]  s_tdata,    // [7:0] char_code
    input  logic        s_tlast,    // line_end
    input  logic        s_tvalid,
    output logic        s_tready,
    // Results.
    output logic [63:0] m_tdata,    // [31:0] base_address, [39:32] byte_index,
                                    // [47:40] data_byte, [51:48] record_kind,
                                    // [55:52] status, [63:56] data_count
    output logic [0:0]  m_tuser,    // [0] is_status
    output logic        m_tvalid,
    input  logic        m_tready,
    // Configuration: address_width.
    input  logic [2:0]  cfg_data,
    input  logic        cfg_valid,
    output logic        cfg_ready
);

    logic [2:0]             address_width_reg;
    logic                   push;
    logic                   pop;
    srld_pkg::srld_item_t   push_item;
    srld_pkg::srld_item_t   head_item;
    srld_pkg::srld_q_stat_t q_stat;

    // The register takes every write as it is offered, so the port never stalls.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            address_width_reg <= srld_pkg::AW_RESET;
        end else if (cfg_valid && cfg_ready) begin
            address_width_reg <= cfg_data;
        end
    end

    // Front end: flags S, digits and hex digits and passes the line end along.
    srld_front u_front (
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tlast   (s_tlast),
        .s_tready  (s_tready),
        .q_stat    (q_stat),
        .push      (push),
        .push_item (push_item)
    );

    // Decoupling queue between classification and parsing.
    srld_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .q_stat    (q_stat)
    );

    // Parser: record state machine, running checksum and result register.
    srld_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .address_width (address_width_reg),
        .head_item     (head_item),
        .q_stat        (q_stat),
        .pop           (pop),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready)
    );

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for srecord_line_decoder_core, the S-record line decoder.
// Needs srld_pkg and the decoder RTL; a directed table is followed by random record lines.
`timescale 1ns / 100ps

module testbench;

    // Record type digits, as the decoder reports them in record_kind.
    localparam logic [3:0] REC_S0 = 4'd0;
    localparam logic [3:0] REC_S1 = 4'd1;
    localparam logic [3:0] REC_S2 = 4'd2;
    localparam logic [3:0] REC_S4 = 4'd4;

    localparam int DIR_ROWS     = 25;
    localparam int PHASES       = 8;
    localparam int HOLD_CYCLES  = 64;    // long receiver hold-off, well past the queue depth
    localparam int SETTLE       = 8;     // margin past the queue depth and the result register
    localparam int DRAIN_LIMIT  = 5000;
    localparam int PRINT_LIMIT  = 40;

    // One decoder result, laid out as {m_tuser, m_tdata}.
    typedef struct packed {
        logic        is_status;
        logic [7:0]  data_count;
        logic [3:0]  status;
        logic [3:0]  record_kind;
        logic [7:0]  data_byte;
        logic [7:0]  byte_index;
        logic [31:0] base_address;
    } srec_result_t;

    // Per-character note from the driver: a typed-in result replaces the prediction.
    typedef struct packed {
        logic         typed;
        srec_result_t res;
    } char_note_t;

    typedef struct packed {
        logic [7:0]   chr;
        logic         last;
        logic         typed;
        srec_result_t res;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [2:0]  cfg_data;
    logic        cfg_valid;
    logic        cfg_ready;

    // Line decoder state kept by the testbench.
    srld_pkg::srld_phase_t ph;
    logic [3:0]  nib;
    logic        half;
    logic [3:0]  rtype;
    logic [7:0]  remain;
    logic [7:0]  rsum;
    logic [31:0] addr;
    logic [7:0]  didx;
    logic [3:0]  err;
    logic [7:0]  dcount;
    logic [2:0]  width_reg;

    srec_result_t decoded_q[$];
    char_note_t   char_notes[$];
    logic [7:0]   line_buf[$];
    dir_row_t     dir_rows[DIR_ROWS];
    logic [2:0]   plan_width[PHASES];
    int           plan_items[PHASES];

    int mismatches;
    int results_seen;
    bit gaps_on;
    bit hold_req;
    bit tail_quiet;

    always #5 aclk = ~aclk;

    srecord_line_decoder_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= srld_pkg::CHAR_0 && c <= srld_pkg::CHAR_9)
            return int'(c - srld_pkg::CHAR_0);
        if (c >= srld_pkg::CHAR_UA && c <= srld_pkg::CHAR_UF)
            return int'(c - srld_pkg::CHAR_UA) + 10;
        if (c >= srld_pkg::CHAR_LA && c <= srld_pkg::CHAR_LF)
            return int'(c - srld_pkg::CHAR_LA) + 10;
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10) return srld_pkg::CHAR_0 + 8'(n);
        return (lower ? srld_pkg::CHAR_LA : srld_pkg::CHAR_UA) + 8'(n - 4'd10);
    endfunction

    function automatic srec_result_t status_res(input logic [3:0] kind,
                                                input logic [3:0] code);
        srec_result_t r;
        r = '0;
        r.is_status   = 1'b1;
        r.record_kind = kind;
        r.status      = code;
        return r;
    endfunction

    function automatic void clear_line();
        ph     = srld_pkg::PH_S;
        nib    = '0;
        half   = 1'b0;
        rtype  = srld_pkg::KIND_NONE;
        remain = '0;
        rsum   = '0;
        addr   = '0;
        didx   = '0;
        err    = srld_pkg::ST_OK;
        dcount = '0;
    endfunction

    // The record is settled: everything up to the line end is ignored from here on.
    function automatic void end_record(input logic [3:0] code);
        err = code;
        ph  = srld_pkg::PH_DONE;
    endfunction

    // Advances the decoder by one character; returns 1 when a result comes out.
    function automatic bit decode_char(input logic [7:0] c, input bit last,
                                       output srec_result_t r);
        int         h;
        int         abytes;
        logic [7:0] b;
        logic [3:0] code;
        bit         emit;
        emit   = 1'b0;
        r      = '0;
        abytes = int'(rtype) + 1;
        case (ph)
            srld_pkg::PH_S: begin
                if (c == srld_pkg::CHAR_S) ph = srld_pkg::PH_TYPE;
                else end_record(srld_pkg::ST_NO_S);
            end
            srld_pkg::PH_TYPE: begin
                if (c < srld_pkg::CHAR_0 || c > srld_pkg::CHAR_9) begin
                    end_record(srld_pkg::ST_BAD_TYPE);
                end else begin
                    rtype = 4'(c - srld_pkg::CHAR_0);
                    case (rtype)
                        REC_S0:           end_record(srld_pkg::ST_START);
                        4'd5, 4'd6:       end_record(srld_pkg::ST_COUNT);
                        4'd7, 4'd8, 4'd9: end_record(srld_pkg::ST_END);
                        4'd1, 4'd2, 4'd3: begin
                            if (int'(rtype) + 1 > int'(width_reg))
                                end_record(srld_pkg::ST_WIDTH);
                            else
                                ph = srld_pkg::PH_COUNT;
                        end
                        default:          end_record(srld_pkg::ST_BAD_TYPE);
                    endcase
                end
            end
            srld_pkg::PH_DONE: ;
            default: begin
                h = hex_nibble(c);
                if (h < 0) begin
                    end_record(srld_pkg::ST_HEX);
                end else if (!half) begin
                    nib  = 4'(h);
                    half = 1'b1;
                end else begin
                    half = 1'b0;
                    b    = {nib, 4'(h)};
                    case (ph)
                        srld_pkg::PH_COUNT: begin
                            rsum = rsum + b;
                            if (int'(b) < abytes + 1) begin
                                end_record(srld_pkg::ST_SHORT);
                            end else begin
                                dcount = 8'(int'(b) - abytes - 1);
                                remain = 8'(abytes);
                                ph     = srld_pkg::PH_ADDR;
                            end
                        end
                        srld_pkg::PH_ADDR: begin
                            rsum   = rsum + b;
                            addr   = {addr[23:0], b};
                            remain = remain - 8'd1;
                            if (remain == 8'd0) begin
                                remain = dcount;
                                didx   = 8'd0;
                                ph     = (dcount == 8'd0) ? srld_pkg::PH_SUM
                                                          : srld_pkg::PH_DATA;
                            end
                        end
                        srld_pkg::PH_DATA: begin
                            rsum           = rsum + b;
                            r.base_address = addr;
                            r.byte_index   = didx;
                            r.data_byte    = b;
                            r.record_kind  = rtype;
                            r.status       = srld_pkg::ST_OK;
                            r.data_count   = dcount;
                            emit           = 1'b1;
                            didx           = didx + 8'd1;
                            remain         = remain - 8'd1;
                            if (remain == 8'd0) ph = srld_pkg::PH_SUM;
                        end
                        srld_pkg::PH_SUM:
                            end_record((8'(~b) == rsum) ? srld_pkg::ST_OK
                                                        : srld_pkg::ST_CHECKSUM);
                        default: ;
                    endcase
                end
            end
        endcase
        if (last) begin
            // The status replaces a data byte completed by the very last character.
            if (ph == srld_pkg::PH_DONE) code = err;
            else if (ph == srld_pkg::PH_S) code = srld_pkg::ST_NO_S;
            else if (ph == srld_pkg::PH_TYPE) code = srld_pkg::ST_BAD_TYPE;
            else code = srld_pkg::ST_HEX;
            r              = status_res(rtype, code);
            r.base_address = addr;
            r.data_count   = dcount;
            emit           = 1'b1;
            clear_line();
        end
        return emit;
    endfunction

    task automatic flag_mismatch(input string msg);
        if (mismatches < PRINT_LIMIT) $display("[%0t] result %0d: %s", $time, results_seen, msg);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s is %0h, %0h predicted", name, got, want));
    endtask

    // Prediction and checking both live here, so they see one consistent edge.
    always @(posedge aclk) begin
        srec_result_t r;
        srec_result_t got;
        srec_result_t want;
        char_note_t   note;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) width_reg = cfg_data;
            if (s_tvalid && s_tready) begin
                note = (char_notes.size() != 0) ? char_notes.pop_front() : '0;
                if (decode_char(s_tdata, s_tlast, r))
                    decoded_q.push_back(note.typed ? note.res : r);
            end
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata};
                results_seen++;
                if (decoded_q.size() == 0) begin
                    flag_mismatch("result arrived with none outstanding");
                end else begin
                    want = decoded_q.pop_front();
                    compare_field("is_status", got.is_status, want.is_status);
                    compare_field("base_address", got.base_address, want.base_address);
                    compare_field("byte_index", got.byte_index, want.byte_index);
                    compare_field("data_byte", got.data_byte, want.data_byte);
                    compare_field("record_kind", got.record_kind, want.record_kind);
                    compare_field("status", got.status, want.status);
                    compare_field("data_count", got.data_count, want.data_count);
                end
            end
        end
    end

    // Offers one character, with an occasional idle burst in front of it.
    task automatic send_char(input logic [7:0] c, input bit last, input bit typed,
                             input srec_result_t res);
        int gap;
        gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        char_notes.push_back('{typed, res});
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stops offering, waits for every outstanding result, then lets the pipeline settle.
    task automatic drain_results();
        int waited;
        s_tvalid <= 1'b0;
        waited = 0;
        do begin
            @(posedge aclk);
            waited++;
        end while (decoded_q.size() != 0 && waited < DRAIN_LIMIT);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_width(input logic [2:0] w);
        cfg_valid <= 1'b1;
        cfg_data  <= w;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic void put_byte(input logic [7:0] b);
        line_buf.push_back(hex_char(b[7:4], $urandom_range(0, 1)));
        line_buf.push_back(hex_char(b[3:0], $urandom_range(0, 1)));
    endfunction

    // Builds one line in line_buf: mostly well-formed data records, some damaged,
    // plus non-data records and plain noise.
    function automatic void make_line();
        int         pick;
        int         t;
        int         ndata;
        int         cnt;
        int         k;
        int         pos;
        logic [7:0] sum;
        logic [7:0] v;
        line_buf.delete();
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
            t     = $urandom_range(1, 3);
            k     = $urandom_range(0, 199);
            ndata = (k < 3) ? 253 - t : (k < 25) ? $urandom_range(9, 40) : $urandom_range(0, 8);
            cnt   = ndata + t + 2;
            if ($urandom_range(0, 19) == 0) cnt = $urandom_range(0, t + 1);
            line_buf.push_back(srld_pkg::CHAR_S);
            line_buf.push_back(srld_pkg::CHAR_0 + 8'(t));
            sum = 8'(cnt);
            put_byte(8'(cnt));
            repeat (t + 1 + ndata) begin
                v   = 8'($urandom);
                sum = sum + v;
                put_byte(v);
            end
            v = ~sum;
            if ($urandom_range(0, 11) == 0) v = v ^ 8'($urandom_range(1, 255));
            put_byte(v);
            k = $urandom_range(0, 19);
            if (k == 0) begin
                // Cut the line short anywhere after the S.
                pos = $urandom_range(1, line_buf.size() - 1);
                while (line_buf.size() > pos) void'(line_buf.pop_back());
            end else if (k == 1) begin
                pos = $urandom_range(2, line_buf.size() - 1);
                do v = 8'($urandom); while (hex_nibble(v) >= 0);
                line_buf[pos] = v;
            end else if (k == 2) begin
                repeat ($urandom_range(1, 4)) line_buf.push_back(8'($urandom));
            end
        end else if (pick < 86) begin
            line_buf.push_back(srld_pkg::CHAR_S);
            line_buf.push_back(srld_pkg::CHAR_0 + 8'($urandom_range(0, 9)));
            repeat ($urandom_range(0, 6)) line_buf.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(1, 6)) line_buf.push_back(8'($urandom));
            if ($urandom_range(0, 1) == 0) line_buf[0] = srld_pkg::CHAR_S;
        end
    endfunction

    // Receiver: random ready bursts, one long hold-off on request, always ready at the end.
    initial begin : sink
        m_tready = 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else if (!tail_quiet && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        int p;
        int i;
        int sent;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        gaps_on    = 1'b1;
        hold_req   = 1'b0;
        tail_quiet = 1'b0;
        mismatches = 0;
        results_seen = 0;
        clear_line();
        width_reg  = srld_pkg::AW_RESET;

        // Register settings per phase, the out-of-range extremes included.
        plan_width = '{3'd4, 3'd3, 3'd0, 3'd7, 3'd1, 3'd5, 3'd2, 3'd4};
        plan_items = '{300, 260, 80, 300, 80, 260, 250, 320};

        dir_rows = '{
            // Line that does not begin with S.
            '{8'h00, 1'b1, 1'b1, status_res(srld_pkg::KIND_NONE, srld_pkg::ST_NO_S)},
            // S alone: the type digit is missing.
            '{srld_pkg::CHAR_S, 1'b1, 1'b1,
              status_res(srld_pkg::KIND_NONE, srld_pkg::ST_BAD_TYPE)},
            // S4 is not a defined record type.
            '{srld_pkg::CHAR_S, 1'b0, 1'b0, '0},
            '{8'h34, 1'b1, 1'b1, status_res(REC_S4, srld_pkg::ST_BAD_TYPE)},
            // S2 needs three address bytes, more than the reset width of two.
            '{srld_pkg::CHAR_S, 1'b0, 1'b0, '0},
            '{8'h32, 1'b1, 1'b1, status_res(REC_S2, srld_pkg::ST_WIDTH)},
            // S0 start record.
            '{srld_pkg::CHAR_S, 1'b0, 1'b0, '0},
            '{8'h30, 1'b1, 1'b1, status_res(REC_S0, srld_pkg::ST_START)},
            // S1 with count 02, one below the minimum of three.
            '{srld_pkg::CHAR_S, 1'b0, 1'b0, '0},
            '{8'h31, 1'b0, 1'b0, '0},
            '{8'h30, 1'b0, 1'b0, '0},
            '{8'h32, 1'b1, 1'b1, status_res(REC_S1, srld_pkg::ST_SHORT)},
            // S1 with 0xFF where the count should begin.
            '{srld_pkg::CHAR_S, 1'b0, 1'b0, '0},
            '{8'h31, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b1, 1'b1, status_res(REC_S1, srld_pkg::ST_HEX)},
            // Shortest valid S1: "S1030000fc", checksum in lower case.
            '{srld_pkg::CHAR_S, 1'b0, 1'b0, '0},
            '{8'h31, 1'b0, 1'b0, '0},
            '{8'h30, 1'b0, 1'b0, '0},
            '{8'h33, 1'b0, 1'b0, '0},
            '{8'h30, 1'b0, 1'b0, '0},
            '{8'h30, 1'b0, 1'b0, '0},
            '{8'h30, 1'b0, 1'b0, '0},
            '{8'h30, 1'b0, 1'b0, '0},
            '{8'h66, 1'b0, 1'b0, '0},
            '{8'h63, 1'b1, 1'b1, status_res(REC_S1, srld_pkg::ST_OK)}
        };

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < DIR_ROWS; i++)
            send_char(dir_rows[i].chr, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].res);

        for (p = 0; p < PHASES; p++) begin
            // The register only changes with the decoder empty and between lines.
            drain_results();
            write_width(plan_width[p]);
            if (p == 1) hold_req = 1'b1;
            if (p == PHASES - 1) tail_quiet = 1'b1;
            sent = 0;
            while (sent < plan_items[p]) begin
                make_line();
                gaps_on = !tail_quiet && ($urandom_range(0, 2) != 0);
                for (i = 0; i < line_buf.size(); i++)
                    send_char(line_buf[i], i == line_buf.size() - 1, 1'b0, '0);
                sent += line_buf.size();
            end
        end

        drain_results();
        if (decoded_q.size() != 0)
            flag_mismatch($sformatf("%0d predicted results never arrived", decoded_q.size()));
        if (mismatches == 0) begin
            $display("srecord_line_decoder_core: match");
        end else begin
            $display("srecord_line_decoder_core: mismatch");
        end
        $finish;
    end

    // Far beyond the slowest correct run, including the drain limits.
    initial begin : watchdog
        #5000000;
        $display("srecord_line_decoder_core: mismatch");
        $finish;
    end

endmodule
